// ===== sv/pcxd_pkg.sv =====
// Shared types and constants for the run-length pixel decoder.
package pcxd_pkg;

    localparam int unsigned COORD_BITS_DEF = 16;
    localparam int unsigned CMD_DEPTH      = 2;
    localparam int unsigned CMD_PTR_W      = $clog2(CMD_DEPTH);
    localparam int unsigned CMD_CNT_W      = $clog2(CMD_DEPTH + 1);
    localparam int unsigned CFG_ADDR_W     = 4;

    localparam logic [1:0] RUN_MARK_BITS = 2'b11;

    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 4'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_X_OFFSET     = 4'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_Y_OFFSET     = 4'd3;

    // One unit of work for the back end: a pixel value repeated len times.
    typedef struct packed {
        logic [7:0] value;
        logic [5:0] len;
    } cmd_t;

    typedef struct packed {
        logic [15:0]        image_width;
        logic [15:0]        image_height;
        logic signed [15:0] x_offset;
        logic signed [15:0] y_offset;
    } cfg_t;

    typedef struct packed {
        logic [7:0]         pixel_value;
        logic signed [15:0] screen_x;
        logic signed [15:0] screen_y;
        logic               last_of_run;
        logic               image_end;
    } pix_t;

endpackage

// ===== sv/pcxd_front.sv =====
// Front end: classifies coded bytes into count bytes and pixel commands.
module pcxd_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            data_byte,
    output logic                  cmd_push,
    output pcxd_pkg::cmd_t        cmd_data
);

    logic       run_pending_reg;
    logic       run_pending_next;
    logic [5:0] run_length_reg;
    logic [5:0] run_length_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_pending_reg <= 1'b0;
            run_length_reg  <= 6'd0;
        end
        else
        begin
            run_pending_reg <= run_pending_next;
            run_length_reg  <= run_length_next;
        end
    end

    always_comb
    begin
        run_pending_next = run_pending_reg;
        run_length_next  = run_length_reg;
        cmd_push         = 1'b0;
        cmd_data.value   = data_byte;
        cmd_data.len     = 6'd1;
        if (accept)
        begin
            if (run_pending_reg)
            begin
                // zero-length run consumes the value byte and makes no work
                run_pending_next = 1'b0;
                run_length_next  = 6'd0;
                cmd_data.len     = run_length_reg;
                cmd_push         = (run_length_reg != 6'd0);
            end
            else if (data_byte[7:6] == pcxd_pkg::RUN_MARK_BITS)
            begin
                run_pending_next = 1'b1;
                run_length_next  = data_byte[5:0];
            end
            else
            begin
                cmd_push = 1'b1;
            end
        end
    end

endmodule

// ===== sv/pcxd_cmd_fifo.sv =====
// Short command queue between the front and back ends.
module pcxd_cmd_fifo
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  pcxd_pkg::cmd_t        push_data,
    input  logic                  pop,
    output pcxd_pkg::cmd_t        pop_data,
    output logic                  avail,
    output logic                  full
);

    localparam int unsigned DEPTH = pcxd_pkg::CMD_DEPTH;
    localparam int unsigned PTR_W = pcxd_pkg::CMD_PTR_W;
    localparam int unsigned CNT_W = pcxd_pkg::CMD_CNT_W;

    pcxd_pkg::cmd_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign avail    = (count_reg != '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/pcxd_back.sv =====
// Back end: expands pixel commands, tracks raster position, holds the result register.
module pcxd_back
#(
    parameter int unsigned COORD_BITS = pcxd_pkg::COORD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  pcxd_pkg::cfg_t        cfg,
    input  logic                  cmd_avail,
    input  pcxd_pkg::cmd_t        cmd_data,
    output logic                  cmd_pop,
    input  logic                  out_pop,
    output logic                  out_valid,
    output pcxd_pkg::pix_t        out_pix
);

    localparam logic [15:0] COORD_MASK = 16'((32'd1 << COORD_BITS) - 32'd1);

    logic           cur_valid_reg;
    logic           cur_valid_next;
    logic [7:0]     cur_value_reg;
    logic [7:0]     cur_value_next;
    logic [5:0]     cur_left_reg;
    logic [5:0]     cur_left_next;
    logic [15:0]    column_reg;
    logic [15:0]    column_next;
    logic [15:0]    row_reg;
    logic [15:0]    row_next;
    logic [31:0]    count_reg;
    logic [31:0]    count_next;
    logic [31:0]    total_reg;
    logic           out_valid_reg;
    logic           out_valid_next;
    pcxd_pkg::pix_t out_reg;

    logic           out_ready;
    logic           emit;
    logic           done;
    logic           last;
    logic           take;
    logic [31:0]    count_inc;
    logic [15:0]    limit;
    logic [15:0]    sum_x;
    logic [15:0]    sum_y;

    assign out_ready = !out_valid_reg || out_pop;
    assign emit      = cur_valid_reg && out_ready;
    assign count_inc = count_reg + 32'd1;
    assign done      = (count_inc == total_reg);
    assign last      = (cur_left_reg == 6'd1) || done;
    assign take      = !cur_valid_reg || (emit && last);
    assign cmd_pop   = take && cmd_avail;
    assign limit     = cfg.image_width - 16'd1;
    assign sum_x     = (column_reg + cfg.x_offset) & COORD_MASK;
    assign sum_y     = (row_reg + cfg.y_offset) & COORD_MASK;
    assign out_valid = out_valid_reg;
    assign out_pix   = out_reg;

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_value_next = cur_value_reg;
        cur_left_next  = cur_left_reg;
        column_next    = column_reg;
        row_next       = row_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;

        if (take)
        begin
            // a run cut short by image end drops its remaining pixels here
            cur_valid_next = cmd_avail;
            cur_value_next = cmd_data.value;
            cur_left_next  = cmd_data.len;
        end
        else if (emit)
        begin
            cur_left_next = cur_left_reg - 6'd1;
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
            if (done)
            begin
                column_next = 16'd0;
                row_next    = 16'd0;
                count_next  = 32'd0;
            end
            else
            begin
                count_next = count_inc;
                if (column_reg < limit)
                begin
                    column_next = column_reg + 16'd1;
                end
                else
                begin
                    column_next = 16'd0;
                    row_next    = row_reg + 16'd1;
                end
            end
        end
        else if (out_pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            cur_left_reg  <= 6'd0;
            column_reg    <= 16'd0;
            row_reg       <= 16'd0;
            count_reg     <= 32'd0;
            out_valid_reg <= 1'b0;
            total_reg     <= 32'd1;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            cur_left_reg  <= cur_left_next;
            column_reg    <= column_next;
            row_reg       <= row_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            total_reg     <= 32'(cfg.image_width) * 32'(cfg.image_height);
        end
    end

    always_ff @(posedge clk)
    begin
        cur_value_reg <= cur_value_next;
        if (emit)
        begin
            out_reg.pixel_value <= cur_value_reg;
            out_reg.screen_x    <= sum_x;
            out_reg.screen_y    <= sum_y;
            out_reg.last_of_run <= last;
            out_reg.image_end   <= done;
        end
    end

endmodule

// ===== sv/pcx_rle_pixel_decoder.sv =====
// Top level of the run-length pixel decoder: configuration registers and wiring.
//
// Input queue side: drive data_byte with push; a byte is taken at a clock edge
// with push high and full low. Result queue side: while empty is low the oldest
// pixel sits on pixel_value, screen_x, screen_y, last_of_run and image_end; it is
// taken at an edge with pop high. Configuration: cfg_we writes cfg_wdata into
// register cfg_addr (0 width, 1 height, 2 x offset, 3 y offset); other indexes
// are ignored. Write registers only while the decoder is idle.
// A literal byte passes through the command queue and current-command register
// into the result register. Literal bytes and run pixels flow at one per cycle
// while the receiver keeps up; a count byte makes no pixel, and the value byte
// after it makes the run, cut short at image end. A run holds the input side
// once the 2-entry command queue fills, as the back end expands one pixel per
// cycle. A stalled receiver freezes the result register, then the back end, then
// the command queue, and finally raises full. Reset clears the queue, any pending
// run and the position counters, and sets width and height to 1 with zero offsets.
module pcx_rle_pixel_decoder
#(
    parameter int unsigned COORD_BITS = pcxd_pkg::COORD_BITS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [7:0]                         data_byte,
    output logic                               empty,
    input  logic                               pop,
    output logic [7:0]                         pixel_value,
    output logic signed [15:0]                 screen_x,
    output logic signed [15:0]                 screen_y,
    output logic                               last_of_run,
    output logic                               image_end,
    input  logic                               cfg_we,
    input  logic [pcxd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [15:0]                        cfg_wdata
);

    pcxd_pkg::cfg_t cfg_reg;
    pcxd_pkg::cmd_t front_cmd;
    pcxd_pkg::cmd_t fifo_cmd;
    pcxd_pkg::pix_t out_pix;
    logic           accept;
    logic           cmd_push;
    logic           cmd_pop;
    logic           cmd_avail;
    logic           out_valid;

    assign accept = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width  <= 16'd1;
            cfg_reg.image_height <= 16'd1;
            cfg_reg.x_offset     <= 16'sd0;
            cfg_reg.y_offset     <= 16'sd0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                pcxd_pkg::REG_IMAGE_WIDTH:  cfg_reg.image_width  <= cfg_wdata;
                pcxd_pkg::REG_IMAGE_HEIGHT: cfg_reg.image_height <= cfg_wdata;
                pcxd_pkg::REG_X_OFFSET:     cfg_reg.x_offset     <= cfg_wdata;
                pcxd_pkg::REG_Y_OFFSET:     cfg_reg.y_offset     <= cfg_wdata;
                default:                    cfg_reg              <= cfg_reg;
            endcase
        end
    end

    pcxd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .cmd_push  (cmd_push),
        .cmd_data  (front_cmd)
    );

    pcxd_cmd_fifo u_cmd_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (front_cmd),
        .pop       (cmd_pop),
        .pop_data  (fifo_cmd),
        .avail     (cmd_avail),
        .full      (full)
    );

    pcxd_back
    #(
        .COORD_BITS (COORD_BITS)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_avail (cmd_avail),
        .cmd_data  (fifo_cmd),
        .cmd_pop   (cmd_pop),
        .out_pop   (pop),
        .out_valid (out_valid),
        .out_pix   (out_pix)
    );

    assign empty       = !out_valid;
    assign pixel_value = out_pix.pixel_value;
    assign screen_x    = out_pix.screen_x;
    assign screen_y    = out_pix.screen_y;
    assign last_of_run = out_pix.last_of_run;
    assign image_end   = out_pix.image_end;

endmodule

// ===== verif/pcx_rle_pixel_decoder_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for pcx_rle_pixel_decoder: directed and random byte streams.
module pcx_rle_pixel_decoder_test;

    // decodes to no register; writes must be ignored
    localparam logic [pcxd_pkg::CFG_ADDR_W-1:0] REG_SPARE = 4'd15;
    localparam int DRAIN_CYCLES = 16;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            push      = 1'b0;
    logic                            full;
    logic [7:0]                      data_byte = '0;
    logic                            empty;
    logic                            pop       = 1'b0;
    logic [7:0]                      pixel_value;
    logic signed [15:0]              screen_x;
    logic signed [15:0]              screen_y;
    logic                            last_of_run;
    logic                            image_end;
    logic                            cfg_we    = 1'b0;
    logic [pcxd_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [15:0]                     cfg_wdata = '0;

    // decoder model: configuration and position state
    logic [15:0] img_w     = 16'd1;
    logic [15:0] img_h     = 16'd1;
    logic [15:0] x_off     = '0;
    logic [15:0] y_off     = '0;
    logic        run_armed = 1'b0;
    logic [5:0]  run_len   = '0;
    logic [15:0] col       = '0;
    logic [15:0] row_idx   = '0;
    logic [31:0] pix_count = '0;

    pcxd_pkg::pix_t pending_pixels[$];
    int             errors      = 0;
    bit             src_steady  = 1'b0;
    bit             sink_steady = 1'b0;

    pcx_rle_pixel_decoder uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .data_byte   (data_byte),
        .empty       (empty),
        .pop         (pop),
        .pixel_value (pixel_value),
        .screen_x    (screen_x),
        .screen_y    (screen_y),
        .last_of_run (last_of_run),
        .image_end   (image_end),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Queue one expected pixel and advance the raster position.
    function automatic bit place_pixel(input logic [7:0] value, input bit last);
        pcxd_pkg::pix_t p;
        logic [31:0]    total;
        logic [15:0]    col_limit;
        logic [31:0]    next_count;
        bit             done;
        total      = {16'd0, img_w} * {16'd0, img_h};
        col_limit  = img_w - 16'd1;
        next_count = pix_count + 32'd1;
        done       = (next_count == total);
        p.pixel_value = value;
        p.screen_x    = col + x_off;
        p.screen_y    = row_idx + y_off;
        p.last_of_run = last || done;
        p.image_end   = done;
        pending_pixels.push_back(p);
        if (done)
        begin
            col       = '0;
            row_idx   = '0;
            pix_count = '0;
        end
        else
        begin
            pix_count = next_count;
            if (col < col_limit)
            begin
                col = col + 16'd1;
            end
            else
            begin
                col     = '0;
                row_idx = row_idx + 16'd1;
            end
        end
        return done;
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        int len;
        len = int'(run_len);
        if (run_armed)
        begin
            run_armed = 1'b0;
            run_len   = '0;
            // a run stops early at the pixel that completes the image
            for (int i = 0; i < len; i++)
            begin
                if (place_pixel(b, i + 1 == len))
                    break;
            end
        end
        else if (b[7:6] == pcxd_pkg::RUN_MARK_BITS)
        begin
            run_armed = 1'b1;
            run_len   = b[5:0];
        end
        else
        begin
            void'(place_pixel(b, 1'b1));
        end
    endfunction

    // Push is left high on return; the next caller lowers it or reuses it.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = src_steady ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push      <= 1'b1;
        data_byte <= b;
        do
            @(posedge clk);
        while (full);
        decode_byte(b);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [pcxd_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic set_geometry(input logic [15:0] w, input logic [15:0] h,
                                input logic [15:0] xo, input logic [15:0] yo);
        write_reg(pcxd_pkg::REG_IMAGE_WIDTH, w);
        write_reg(REG_SPARE, 16'($urandom_range(0, 65535)));
        write_reg(pcxd_pkg::REG_IMAGE_HEIGHT, h);
        write_reg(pcxd_pkg::REG_X_OFFSET, xo);
        write_reg(pcxd_pkg::REG_Y_OFFSET, yo);
        cfg_we <= 1'b0;
        img_w = w;
        img_h = h;
        x_off = xo;
        y_off = yo;
    endtask

    function automatic void compare_field(input string name, input logic [15:0] want,
                                          input logic [15:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
        end
    endfunction

    task automatic check_pixel();
        pcxd_pkg::pix_t want;
        if (pending_pixels.size() == 0)
        begin
            errors++;
            $display("%0t ns: unexpected pixel, expected none, actual %0h x %0h y %0h",
                     $time, pixel_value, screen_x, screen_y);
            return;
        end
        want = pending_pixels.pop_front();
        compare_field("pixel_value", 16'(want.pixel_value), 16'(pixel_value));
        compare_field("screen_x", want.screen_x, screen_x);
        compare_field("screen_y", want.screen_y, screen_y);
        compare_field("last_of_run", 16'(want.last_of_run), 16'(last_of_run));
        compare_field("image_end", 16'(want.image_end), 16'(image_end));
    endtask

    // Result side: check each transaction, then stall pop at random before the next.
    initial
    begin : pixel_sink
        int unsigned hold;
        hold = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                check_pixel();
                hold = sink_steady ? 0 : $urandom_range(0, 10);
            end
            else if (hold > 0)
            begin
                hold--;
            end
            pop <= (hold == 0);
        end
    end

    function automatic logic [15:0] pick_width();
        case ($urandom_range(0, 9))
            0:       return 16'hFFFF;
            1:       return 16'd1;
            2, 3, 4, 5, 6: return 16'($urandom_range(1, 8));
            default: return 16'($urandom_range(9, 300));
        endcase
    endfunction

    function automatic logic [15:0] pick_height();
        case ($urandom_range(0, 9))
            0:       return 16'hFFFF;
            1:       return 16'd1;
            default: return 16'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [15:0] pick_offset();
        case ($urandom_range(0, 5))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Reset values: every pixel is a whole 1x1 image.
    task automatic test_default_geometry();
        send_byte(8'h00);
        send_byte(8'hBF);
        send_byte(8'h7F);
        send_byte(8'hC3);   // run cut short at image end
        send_byte(8'hFF);
        send_byte(8'hC0);   // zero-length run: value byte makes nothing
        send_byte(8'h55);
        drain();
    endtask

    // Small image with offsets at the signed extremes so positions wrap.
    task automatic test_wrapping_offsets();
        set_geometry(16'd3, 16'd2, 16'h7FFF, 16'h8000);
        send_byte(8'h80);
        send_byte(8'hFF);   // longest run, overruns the image
        send_byte(8'h00);
        send_byte(8'hC1);
        send_byte(8'hC5);   // run value with the count marker bits set
        send_byte(8'h3F);
        send_byte(8'h01);
        drain();
    endtask

    task automatic test_full_size_image();
        set_geometry(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_byte(8'h40);
        send_byte(8'hC2);
        send_byte(8'hAA);
        send_byte(8'hC0);
        send_byte(8'hC0);
        drain();
    endtask

    // Mostly literals and count/value pairs, some raw noise bytes.
    task automatic test_random_traffic();
        int          sent;
        int unsigned pick;
        for (int phase = 0; phase < 5; phase++)
        begin
            src_steady  = (phase == 1 || phase == 3);
            sink_steady = (phase == 2 || phase == 3);
            set_geometry(pick_width(), pick_height(), pick_offset(), pick_offset());
            sent = 0;
            while (sent < 78)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 11)
                begin
                    send_byte(8'($urandom_range(0, 191)));
                    sent++;
                end
                else if (pick < 18)
                begin
                    send_byte({pcxd_pkg::RUN_MARK_BITS, 6'($urandom_range(0, 63))});
                    send_byte(8'($urandom_range(0, 255)));
                    sent += 2;
                end
                else
                begin
                    send_byte(8'($urandom_range(0, 255)));
                    sent++;
                end
            end
            drain();
        end
        src_steady  = 1'b0;
        sink_steady = 1'b0;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_geometry();
        test_wrapping_offsets();
        test_full_size_image();
        test_random_traffic();
        drain();
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== pcx_rle_pixel_decoder.f =====
sv/pcxd_pkg.sv
sv/pcxd_front.sv
sv/pcxd_cmd_fifo.sv
sv/pcxd_back.sv
sv/pcx_rle_pixel_decoder.sv
verif/pcx_rle_pixel_decoder_test.sv
